>>> hdl/zeck_pkg.sv
// ----------------------------------------------------------------------------
// zeck_pkg
// Shared types and constants for the Fibonacci-base (Zeckendorf) adder.
// ----------------------------------------------------------------------------
package zeck_pkg;

	// Operand and result geometry
	localparam int OPERAND_DIGITS_DEF = 61;
	localparam int SUM_DIGITS         = 64;
	localparam int LEN_W              = 7;
	localparam int IDX_W              = 6;

	// Bus widths, fields packed from the low bits and padded to whole bytes
	localparam int S_TDATA_W = 128;
	localparam int M_TDATA_W = 72;

	// Integer value of any sum is below W(64) < 2**45
	localparam int VAL_W = 46;

	// Digit weights W(i) = F(i+2) at the two top result positions
	localparam logic [VAL_W-1:0] W_TOP  = 46'd17167680177565; // W(63)
	localparam logic [VAL_W-1:0] W_NEXT = 46'd10610209857723; // W(62)

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_REDUCE,
		ST_DONE
	} zeck_state_t;

endpackage

>>> hdl/zeckendorf_adder.sv
// ----------------------------------------------------------------------------
// zeckendorf_adder
// Adds two Fibonacci-base operands and returns the normalized sum and its
// significant digit count, using one shared add/subtract datapath.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake          Payload (low bit first)
// s_*      in   s_tvalid/s_tready  addend_a[60:0], addend_b[121:61]
// m_*      out  m_tvalid/m_tready  sum_digits[63:0], sum_length[70:64]
//
// An item first converts both operands to an integer (one digit position per
// cycle through the shared adder), then runs greedy subtraction from the top
// weight down (one digit per cycle).
// s_tready is high only while the block is idle; a result waiting on
// m_tready holds its data and keeps the input closed.
// Reset clears the sequencer and output valid; no clearing pass is needed.
//
module zeckendorf_adder #(
	parameter int OPERAND_DIGITS = zeck_pkg::OPERAND_DIGITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [zeck_pkg::S_TDATA_W-1:0] s_tdata,  // addend_a, addend_b, pad
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [zeck_pkg::M_TDATA_W-1:0] m_tdata   // sum_digits, sum_length, pad
);

	localparam int VW = zeck_pkg::VAL_W;
	localparam int IW = zeck_pkg::IDX_W;
	localparam int LW = zeck_pkg::LEN_W;
	localparam int SW = zeck_pkg::SUM_DIGITS;
	localparam int FW = 61;

	zeck_pkg::zeck_state_t state_q, state_d;

	logic [OPERAND_DIGITS-1:0] a_q, b_q;
	logic [VW-1:0]             acc_q;
	logic [VW-1:0]             w_hi_q, w_lo_q;
	logic [IW-1:0]             cnt_q;
	logic [SW-1:0]             sum_q;
	logic [LW-1:0]             len_q;

	logic          in_acc, last_step;
	logic [VW-1:0] add_term;
	logic [VW:0]   diff;
	logic          take;
	logic [LW-1:0] pos_len;

	assign in_acc    = s_tvalid && s_tready;
	assign last_step = (cnt_q == '0);

	// Term for one digit position of both operands: 0, W or 2W
	always_comb begin
		case ({a_q[0], b_q[0]})
			2'b11:   add_term = {w_lo_q[VW-2:0], 1'b0};
			2'b10,
			2'b01:   add_term = w_lo_q;
			default: add_term = '0;
		endcase
	end

	// Greedy step: take the weight when the remainder covers it
	assign diff    = {1'b0, acc_q} - {1'b0, w_hi_q};
	assign take    = !diff[VW];
	assign pos_len = {1'b0, cnt_q} + LW'(1);

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= zeck_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance through convert, reduce and deliver
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			zeck_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = zeck_pkg::ST_ACCUM;
			end
			zeck_pkg::ST_ACCUM: begin
				if (last_step) state_d = zeck_pkg::ST_REDUCE;
			end
			zeck_pkg::ST_REDUCE: begin
				if (last_step) state_d = zeck_pkg::ST_DONE;
			end
			zeck_pkg::ST_DONE: begin
				m_tvalid = 1'b1;
				if (m_tready) state_d = zeck_pkg::ST_IDLE;
			end
			default: state_d = zeck_pkg::ST_IDLE;
		endcase
	end

	// Shared datapath: accumulate operand value, then peel off weights
	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_q    <= s_tdata[OPERAND_DIGITS-1:0];
			b_q    <= s_tdata[FW +: OPERAND_DIGITS];
			acc_q  <= '0;
			w_lo_q <= VW'(1);
			w_hi_q <= VW'(2);
			cnt_q  <= IW'(OPERAND_DIGITS - 1);
		end else if (state_q == zeck_pkg::ST_ACCUM) begin
			acc_q  <= acc_q + add_term;
			a_q    <= a_q >> 1;
			b_q    <= b_q >> 1;
			if (last_step) begin
				w_hi_q <= zeck_pkg::W_TOP;
				w_lo_q <= zeck_pkg::W_NEXT;
				cnt_q  <= IW'(SW - 1);
				sum_q  <= '0;
				len_q  <= LW'(1);
			end else begin
				w_lo_q <= w_hi_q;
				w_hi_q <= w_hi_q + w_lo_q;
				cnt_q  <= cnt_q - IW'(1);
			end
		end else if (state_q == zeck_pkg::ST_REDUCE) begin
			sum_q  <= {sum_q[SW-2:0], take};
			w_hi_q <= w_lo_q;
			w_lo_q <= w_hi_q - w_lo_q;
			cnt_q  <= cnt_q - IW'(1);
			if (take) begin
				acc_q <= diff[VW-1:0];
				if (len_q < pos_len) len_q <= pos_len;
			end
		end
	end

	assign m_tdata = {1'b0, len_q, sum_q};

	// Input and output never open at the same time
	assert property (@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid))
		else $error("input and output both open");

	// Normalized form: no two adjacent digits while reducing or delivering
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == zeck_pkg::ST_REDUCE || state_q == zeck_pkg::ST_DONE)
		|-> ((sum_q & (sum_q >> 1)) == '0))
		else $error("adjacent digits set in sum");

	// The whole value is consumed by the greedy pass
	assert property (@(posedge clk) disable iff (!arst_n) m_tvalid |-> (acc_q == '0))
		else $error("remainder left after reduction");

	// Length in range and consistent with the top digit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (len_q >= LW'(1) && len_q <= LW'(SW)
			&& (sum_q >> len_q) == '0))
		else $error("sum length out of range");

endmodule
